### src/scfl_pkg.sv
`timescale 1ns / 1ps

package scfl_pkg;

  // Sizing; LINE_BYTES is a power of two
  localparam int LINE_BYTES   = 64;
  localparam int NUM_CLASSES  = 16;
  localparam int STACK_DEPTH  = 64;
  localparam int REGION_BYTES = 2097152;
  localparam int HDR_BYTES    = 8;

  localparam int LINE_W      = $clog2(LINE_BYTES);
  localparam int CLASS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int STACK_WORDS = NUM_CLASSES * STACK_DEPTH;
  localparam int MEM_AW      = $clog2(STACK_WORDS);
  localparam int REM_W       = $clog2(REGION_BYTES);

  // Beat field widths
  localparam int CMD_W        = 2;
  localparam int BYTES_W      = 32;
  localparam int ADDR_W       = 48;
  localparam int STATUS_W     = 2;
  localparam int SIZE_CLASS_W = 4;
  localparam int IN_DATA_W    = 80;
  localparam int OUT_DATA_W   = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REGION = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_LARGE       = 2'd1,
    STAT_NEED_REGION = 2'd2,
    STAT_FULL        = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ASEL_ZERO = 2'd0,
    ASEL_BUMP = 2'd1,
    ASEL_MEM  = 2'd2
  } addr_sel_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_POP  = 2'd2,
    S_LEFT = 2'd3
  } state_t;

  typedef struct packed {
    cmd_t cmd;
    logic bad_class;
    logic stack_hit;
    logic stack_full;
    logic carve_fits;
    logic left_push_ok;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic      capture;
    logic      sel_left;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      mem_re;
    logic      mem_we;
    logic      bump_carve;
    logic      bump_region;
    logic      bump_clear;
    logic      res_load;
    status_t   res_status;
    addr_sel_t res_addr;
    logic      res_cls_zero;
  } dp_cmd_t;

endpackage

### src/scfl_ram.sv
`timescale 1ns / 1ps

module scfl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/scfl_ctrl.sv
`timescale 1ns / 1ps

module scfl_ctrl
  import scfl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    ctl              = '0;
    ctl.res_status   = STAT_OK;
    ctl.res_addr     = ASEL_ZERO;
    s_tready         = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          CMD_ALLOC: begin
            if (stat.bad_class) begin
              if (!stat.out_busy) begin
                ctl.res_load     = 1'b1;
                ctl.res_status   = STAT_LARGE;
                ctl.res_cls_zero = 1'b1;
                state_next       = S_IDLE;
              end
            end else if (stat.stack_hit) begin
              // pop: read now, answer from the registered read data in S_POP
              ctl.cnt_dec = 1'b1;
              ctl.mem_re  = 1'b1;
              state_next  = S_POP;
            end else if (stat.carve_fits) begin
              if (!stat.out_busy) begin
                ctl.bump_carve = 1'b1;
                ctl.res_load   = 1'b1;
                ctl.res_addr   = ASEL_BUMP;
                state_next     = S_IDLE;
              end
            end else begin
              state_next = S_LEFT;
            end
          end
          CMD_FREE: begin
            if (!stat.out_busy) begin
              ctl.res_load = 1'b1;
              state_next   = S_IDLE;
              if (stat.bad_class) begin
                ctl.res_status   = STAT_LARGE;
                ctl.res_cls_zero = 1'b1;
              end else if (stat.stack_full) begin
                ctl.res_status = STAT_FULL;
              end else begin
                ctl.mem_we  = 1'b1;
                ctl.cnt_inc = 1'b1;
              end
            end
          end
          CMD_REGION: begin
            if (!stat.out_busy) begin
              ctl.bump_region  = 1'b1;
              ctl.res_load     = 1'b1;
              ctl.res_cls_zero = 1'b1;
              state_next       = S_IDLE;
            end
          end
          CMD_NONE: begin
            if (!stat.out_busy) begin
              ctl.res_load     = 1'b1;
              ctl.res_cls_zero = 1'b1;
              state_next       = S_IDLE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        if (!stat.out_busy) begin
          ctl.res_load = 1'b1;
          ctl.res_addr = ASEL_MEM;
          state_next   = S_IDLE;
        end
      end
      S_LEFT: begin
        ctl.sel_left = 1'b1;
        if (!stat.out_busy) begin
          ctl.mem_we     = stat.left_push_ok;
          ctl.cnt_inc    = stat.left_push_ok;
          ctl.bump_clear = 1'b1;
          ctl.res_load   = 1'b1;
          ctl.res_status = STAT_NEED_REGION;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/scfl_datapath.sv
`timescale 1ns / 1ps

module scfl_datapath
  import scfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CMD_W-1:0]      s_tuser,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  dp_cmd_t               ctl,
  output dp_stat_t              stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [STATUS_W-1:0]   m_tuser,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = BYTES_W + 1 - LINE_W;
  localparam int LN_W  = BYTES_W - LINE_W;
  localparam int RL_W  = REM_W - LINE_W;

  // Captured beat
  cmd_t               cmd_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [ADDR_W-1:0]  addr_q;

  // Allocator state
  logic [ADDR_W-1:0]  bump_ptr;
  logic [REM_W-1:0]   bump_rem;
  logic [COUNT_W-1:0] counts [NUM_CLASSES];

  // Result register
  logic                    out_valid;
  status_t                 out_status;
  logic [ADDR_W-1:0]       out_addr;
  logic [SIZE_CLASS_W-1:0] out_cls;

  logic [BYTES_W:0]   alloc_sum;
  logic [IDX_W-1:0]   alloc_idx;
  logic               alloc_large;
  logic [LN_W-1:0]    free_lines;
  logic               free_bad;
  logic [CLASS_W-1:0] req_cls;
  logic [CLASS_W:0]   req_cls_p1;
  logic [REM_W-1:0]   block;
  logic [RL_W-1:0]    rem_lines;
  logic [CLASS_W-1:0] left_cls;
  logic [CLASS_W-1:0] cls_sel;
  logic [COUNT_W-1:0] cnt;
  logic [DEPTH_W-1:0] slot;
  logic [MEM_AW-1:0]  mem_addr;
  logic [ADDR_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_rdata;
  logic [ADDR_W-1:0]  res_addr;

  // Class decode: alloc rounds bytes+header up to lines, free takes whole lines
  assign alloc_sum   = {1'b0, bytes_q} + (BYTES_W + 1)'(HDR_BYTES - 1);
  assign alloc_idx   = alloc_sum[BYTES_W:LINE_W];
  assign alloc_large = (alloc_idx >= IDX_W'(NUM_CLASSES));
  assign free_lines  = bytes_q[BYTES_W-1:LINE_W];
  assign free_bad    = (free_lines == '0) || (free_lines > LN_W'(NUM_CLASSES));
  assign req_cls     = (cmd_q == CMD_ALLOC) ? CLASS_W'(alloc_idx)
                                            : CLASS_W'(free_lines - LN_W'(1));
  assign req_cls_p1  = {1'b0, req_cls} + (CLASS_W + 1)'(1);
  assign block       = REM_W'(req_cls_p1) << LINE_W;

  // Leftover of a region that is too small
  assign rem_lines = bump_rem[REM_W-1:LINE_W];
  assign left_cls  = CLASS_W'(rem_lines - RL_W'(1));

  assign cls_sel = ctl.sel_left ? left_cls : req_cls;
  assign cnt     = counts[cls_sel];

  // Pop reads the top entry, push writes one past it
  assign slot      = ctl.mem_re ? DEPTH_W'(cnt - COUNT_W'(1)) : DEPTH_W'(cnt);
  assign mem_addr  = MEM_AW'(cls_sel) * MEM_AW'(STACK_DEPTH) + MEM_AW'(slot);
  assign mem_wdata = ctl.sel_left ? bump_ptr : addr_q;

  scfl_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (STACK_WORDS)
  ) u_stacks (
    .clk   (clk),
    .we    (ctl.mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (ctl.mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_comb begin
    stat.cmd          = cmd_q;
    stat.bad_class    = (cmd_q == CMD_ALLOC) ? alloc_large : free_bad;
    stat.stack_hit    = (cnt != '0);
    stat.stack_full   = (cnt == COUNT_W'(STACK_DEPTH));
    stat.carve_fits   = (bump_rem >= block);
    stat.left_push_ok = (rem_lines != '0) && (rem_lines <= RL_W'(NUM_CLASSES)) &&
                        (cnt != COUNT_W'(STACK_DEPTH));
    stat.out_busy     = out_valid && !m_tready;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= cmd_t'(s_tuser);
      bytes_q <= s_tdata[BYTES_W-1:0];
      addr_q  <= s_tdata[BYTES_W +: ADDR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump_ptr <= '0;
      bump_rem <= '0;
    end else if (ctl.bump_region) begin
      bump_ptr <= addr_q + ADDR_W'(LINE_BYTES);
      bump_rem <= REM_W'(REGION_BYTES - LINE_BYTES);
    end else if (ctl.bump_carve) begin
      bump_ptr <= bump_ptr + ADDR_W'(block);
      bump_rem <= bump_rem - block;
    end else if (ctl.bump_clear) begin
      bump_rem <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= '0;
      end
    end else if (ctl.cnt_inc) begin
      counts[cls_sel] <= cnt + COUNT_W'(1);
    end else if (ctl.cnt_dec) begin
      counts[cls_sel] <= cnt - COUNT_W'(1);
    end
  end

  always_comb begin
    unique case (ctl.res_addr)
      ASEL_BUMP: res_addr = bump_ptr;
      ASEL_MEM:  res_addr = mem_rdata;
      default:   res_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_status <= ctl.res_status;
      out_addr   <= res_addr;
      out_cls    <= ctl.res_cls_zero ? '0 : SIZE_CLASS_W'(req_cls);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(OUT_DATA_W - ADDR_W - SIZE_CLASS_W){1'b0}}, out_cls, out_addr};

endmodule

### src/size_class_free_list_allocator.sv
`timescale 1ns / 1ps
// Size-class allocator: per-class free stacks in one RAM plus a bump region.
// Steps: beat captured, then decoded and executed into the result register; a
// stack pop adds a RAM read step, an alloc that exhausts the region a leftover
// push step. A new beat is taken only once the last one's result is loaded, for
// the read-then-update turn on the class counts, stack RAM and bump registers.
// Reset (rst, sync): counts and bump pointer/remaining cleared; RAM not cleared.

module size_class_free_list_allocator
  import scfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Command side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CMD_W-1:0]      s_tuser,   // [1:0] cmd
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] request_bytes, [79:32] address
  // Result side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [STATUS_W-1:0]   m_tuser,   // [1:0] status
  output logic [OUT_DATA_W-1:0] m_tdata    // [47:0] address_out, [51:48] size_class, pad
);

  dp_stat_t stat;
  dp_cmd_t  ctl;

  // Sequencer: take beat, decode/execute, optional pop or leftover step.
  // Each step that produces a result holds off while the result register is
  // still occupied, so a waiting result never blocks the next beat's capture.
  scfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Class decode, per-class counts, stack RAM, bump region, result register.
  scfl_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .ctl      (ctl),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

endmodule

### bench/size_class_free_list_allocator_tb.sv
`timescale 1ns / 1ps

module size_class_free_list_allocator_tb;
  import scfl_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 960;
  localparam int MAX_GAP      = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int TOP_CLASS    = NUM_CLASSES - 1;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] bytes;
    logic [47:0] addr;
  } alloc_cmd_t;

  typedef struct {
    status_t     status;
    logic [47:0] addr;
    logic [3:0]  cls;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CMD_W-1:0]      s_tuser  = '0;   // [1:0] cmd
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [31:0] request_bytes, [79:32] address
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [STATUS_W-1:0]   m_tuser;         // [1:0] status
  logic [OUT_DATA_W-1:0] m_tdata;         // [47:0] address_out, [51:48] size_class

  size_class_free_list_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Allocator model: per-class pointer stacks, bump pointer and region remainder
  // ---------------------------------------------------------------------------
  logic [47:0] free_stack [NUM_CLASSES][STACK_DEPTH];
  int unsigned free_count [NUM_CLASSES];
  logic [47:0] bump_ptr = '0;
  int unsigned bump_left = 0;

  initial begin
    foreach (free_count[i]) free_count[i] = 0;
  end

  function automatic bit stack_push(int unsigned cls, logic [47:0] ptr);
    if (cls >= NUM_CLASSES || free_count[cls] >= STACK_DEPTH) return 1'b0;
    free_stack[cls][free_count[cls]] = ptr;
    free_count[cls]++;
    return 1'b1;
  endfunction

  function automatic alloc_result_t allocate_step(alloc_cmd_t c);
    alloc_result_t r;
    logic [33:0]   rounded;
    int unsigned   idx;
    int unsigned   blk;
    logic [31:0]   lines;
    bit            ok;
    r = '{STAT_OK, '0, '0};
    case (c.cmd)
      CMD_ALLOC: begin
        // header added, then rounded up to whole lines; lines-1 is the class
        rounded = 34'(c.bytes) + 34'(HDR_BYTES - 1);
        rounded = rounded / LINE_BYTES;
        if (rounded >= NUM_CLASSES) begin
          r.status = STAT_LARGE;
        end else begin
          idx   = int'(rounded);
          r.cls = idx[3:0];
          if (free_count[idx] != 0) begin
            free_count[idx]--;
            r.addr = free_stack[idx][free_count[idx]];
          end else begin
            blk = LINE_BYTES * (idx + 1);
            if (bump_left >= blk) begin
              r.addr    = bump_ptr;
              bump_ptr  = bump_ptr + 48'(blk);
              bump_left = bump_left - blk;
            end else begin
              // region exhausted: leftover goes back as a free block if it can
              if (bump_left >= LINE_BYTES)
                ok = stack_push(bump_left / LINE_BYTES - 1, bump_ptr);
              bump_left = 0;
              r.status  = STAT_NEED_REGION;
            end
          end
        end
      end
      CMD_FREE: begin
        lines = c.bytes / LINE_BYTES;
        if (lines == 0 || lines > NUM_CLASSES) begin
          r.status = STAT_LARGE;
        end else begin
          idx   = int'(lines) - 1;
          r.cls = idx[3:0];
          if (!stack_push(idx, c.addr)) r.status = STAT_FULL;
        end
      end
      CMD_REGION: begin
        bump_ptr  = c.addr + 48'(LINE_BYTES);
        bump_left = REGION_BYTES - LINE_BYTES;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  alloc_cmd_t    cmd_queue[$];
  alloc_result_t awaited[$];

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic logic [31:0] alloc_bytes(int cls);
    int lo;
    int hi;
    lo = (cls == 0) ? 0 : cls * LINE_BYTES - HDR_BYTES + 1;
    hi = cls * LINE_BYTES + LINE_BYTES - HDR_BYTES;
    return 32'($urandom_range(hi, lo));
  endfunction

  function automatic logic [31:0] free_bytes(int cls);
    return 32'((cls + 1) * LINE_BYTES + $urandom_range(LINE_BYTES - 1, 0));
  endfunction

  task automatic add_cmd(cmd_t c, logic [31:0] b, logic [47:0] a);
    cmd_queue.push_back('{c, b, a});
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: one beat per queued item, random gap before each
  // ---------------------------------------------------------------------------
  alloc_cmd_t cur_cmd;
  int         send_gap   = 0;
  int         send_beats = 0;
  bit         send_quiet = 1'b0;

  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        awaited.push_back(allocate_step(cur_cmd));
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_queue.size() != 0) begin
          cur_cmd = cmd_queue.pop_front();
          s_tuser <= cur_cmd.cmd;
          s_tdata <= {cur_cmd.addr, cur_cmd.bytes};
          nv = 1'b1;
          // stretches with no idling now and then
          if (send_beats % 64 == 0) send_quiet = ($urandom_range(3, 0) == 0);
          send_beats++;
          send_gap = send_quiet ? 0 : $urandom_range(MAX_GAP, 0);
        end
      end
      s_tvalid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random ready gaps plus long hold-offs to back up the block
  // ---------------------------------------------------------------------------
  int errors       = 0;
  int results_seen = 0;
  int recv_gap     = 0;
  int hold_left    = 0;
  bit recv_quiet   = 1'b0;

  task automatic note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    alloc_result_t ex;
    logic          nr;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          note_error($sformatf("unexpected beat status=%0d addr=%h cls=%0d",
                               m_tuser, m_tdata[47:0], m_tdata[51:48]));
        end else begin
          ex = awaited.pop_front();
          if (m_tuser != ex.status || m_tdata[47:0] != ex.addr || m_tdata[51:48] != ex.cls)
            note_error($sformatf("beat %0d exp status=%0d addr=%h cls=%0d got %0d %h %0d",
                                 results_seen, ex.status, ex.addr, ex.cls,
                                 m_tuser, m_tdata[47:0], m_tdata[51:48]));
        end
        results_seen++;
        if (results_seen % 64 == 0) recv_quiet = ($urandom_range(3, 0) == 0);
        recv_gap = recv_quiet ? 0 : $urandom_range(MAX_GAP, 0);
        if (results_seen == 30 || results_seen == 600) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      m_tready <= nr;
    end
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int total;
    int hot;
    int pick;
    int cls;
    // directed: reset state, edges of the size fields, wrap of the bump pointer
    add_cmd(CMD_ALLOC, 32'd0, 48'd0);                  // no region yet, nothing left
    add_cmd(CMD_NONE, 32'hFFFF_FFFF, '1);              // unused command
    add_cmd(CMD_ALLOC, 32'hFFFF_FFFF, '1);             // large, sum past 32 bits
    add_cmd(CMD_ALLOC, 32'd1017, 48'd0);               // first size past the top class
    add_cmd(CMD_ALLOC, 32'd1016, 48'd0);               // top class, no region
    add_cmd(CMD_FREE, 32'd0, rand48());                // below one line
    add_cmd(CMD_FREE, 32'd63, rand48());
    add_cmd(CMD_FREE, 32'd1088, rand48());             // past the top class
    add_cmd(CMD_FREE, 32'hFFFF_FFFF, '1);
    add_cmd(CMD_FREE, 32'd64, '1);                     // class 0 push of all ones
    add_cmd(CMD_ALLOC, 32'd56, 48'd0);                 // pops it back
    add_cmd(CMD_FREE, 32'd1087, rand48());
    add_cmd(CMD_ALLOC, 32'd953, 48'd0);                // top class pop
    add_cmd(CMD_REGION, 32'hFFFF_FFFF, '1);            // base+line wraps
    add_cmd(CMD_ALLOC, 32'd57, 48'd0);
    add_cmd(CMD_ALLOC, 32'd0, 48'd0);
    add_cmd(CMD_REGION, 32'd0, 48'd0);                 // old remainder discarded
    add_cmd(CMD_ALLOC, 32'd1016, 48'd0);
    add_cmd(CMD_REGION, 32'd0, rand48());

    // one class stack filled past full: the extra free reports list_full
    cls = $urandom_range(TOP_CLASS, 0);
    repeat (STACK_DEPTH + 1) add_cmd(CMD_FREE, free_bytes(cls), rand48());
    add_cmd(CMD_ALLOC, alloc_bytes(cls), 48'd0);

    // random traffic: mostly well-formed, one class at a time gets extra frees
    add_cmd(CMD_REGION, $urandom(), rand48());
    hot = $urandom_range(TOP_CLASS, 0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 199) hot = $urandom_range(TOP_CLASS, 0);
      pick = $urandom_range(99, 0);
      cls  = $urandom_range(TOP_CLASS, 0);
      if (pick < 44) begin
        add_cmd(CMD_ALLOC, alloc_bytes(cls), rand48());
      end else if (pick < 64) begin
        add_cmd(CMD_FREE, free_bytes(cls), rand48());
      end else if (pick < 78) begin
        add_cmd(CMD_FREE, free_bytes(hot), rand48());
      end else if (pick < 86) begin
        add_cmd(CMD_REGION, $urandom(), rand48());
      end else if (pick < 88) begin
        add_cmd(CMD_NONE, $urandom(), rand48());
      end else if (pick < 94) begin
        add_cmd(CMD_ALLOC, $urandom(), rand48());
      end else begin
        add_cmd(CMD_FREE, $urandom(), rand48());
      end
    end
    total = cmd_queue.size();

    while (results_seen < total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited.size() != 0) note_error("results still outstanding at end");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/scfl_pkg.sv
src/scfl_ram.sv
src/scfl_ctrl.sv
src/scfl_datapath.sv
src/size_class_free_list_allocator.sv
bench/size_class_free_list_allocator_tb.sv
